@@ rtl/dhs_pkg.sv @@
// ----------------------------------------------------------------------------
// dhs_pkg: shared types and constants for the defrost heater sequencer
// Register indexes, reset values, stream packing and the controller state.
// ----------------------------------------------------------------------------
package dhs_pkg;

    localparam int CntW      = 16;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;
    localparam int InTdataW  = 24;
    localparam int OutTdataW = 8;

    localparam logic [CntW-1:0] CntSat = '1;

    // Register indexes on the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_WARM_THRESHOLD    = 3'd0,
        CFG_HEATER_TIMEOUT    = 3'd1,
        CFG_DROPPER_TIME      = 3'd2,
        CFG_EVAP_CHECK_TIME   = 3'd3,
        CFG_PLUGIN_CHECK_TIME = 3'd4
    } cfg_index_t;

    localparam logic signed [CntW-1:0] RstWarmThreshold   = 16'sd100;
    localparam logic [CntW-1:0]        RstHeaterTimeout   = 16'd1800;
    localparam logic [CntW-1:0]        RstDropperTime     = 16'd600;
    localparam logic [CntW-1:0]        RstEvapCheckTime   = 16'd60;
    localparam logic [CntW-1:0]        RstPluginCheckTime = 16'd5;

    typedef struct packed {
        logic signed [CntW-1:0] warm_threshold;
        logic [CntW-1:0]        heater_timeout;
        logic [CntW-1:0]        dropper_time;
        logic [CntW-1:0]        evap_check_time;
        logic [CntW-1:0]        plugin_check_time;
    } cfg_t;

    typedef struct packed {
        logic signed [CntW-1:0] evap_reading;
        logic                   evap_error;
        logic                   plugin_request;
        logic                   defrost_request;
        logic                   tick;
    } item_t;

    typedef struct packed {
        logic compressor_timer_reset;
        logic beep;
        logic heat_error;
        logic plugin_active;
        logic defrost_active;
        logic heater_drive;
    } result_t;

    typedef struct packed {
        logic            heater_on;
        logic            defrost_flag;
        logic            plugin_flag;
        logic            heat_error_flag;
        logic [CntW-1:0] on_seconds;
        logic [CntW-1:0] drip_seconds;
        logic            mark_running;
        logic [CntW-1:0] since_mark;
    } state_t;

    localparam state_t StateRst = '0;

endpackage

@@ rtl/dhs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dhs_cfg_regs: configuration register file
// Five 16-bit registers written through a plain write port, no read-back.
// ----------------------------------------------------------------------------
module dhs_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dhs_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [dhs_pkg::CfgDataW-1:0]  cfg_wdata,
    output dhs_pkg::cfg_t                 cfg
);

    dhs_pkg::cfg_t cfg_reg;
    dhs_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (dhs_pkg::cfg_index_t'(cfg_index))
                dhs_pkg::CFG_WARM_THRESHOLD:    cfg_next.warm_threshold    = $signed(cfg_wdata);
                dhs_pkg::CFG_HEATER_TIMEOUT:    cfg_next.heater_timeout    = cfg_wdata;
                dhs_pkg::CFG_DROPPER_TIME:      cfg_next.dropper_time      = cfg_wdata;
                dhs_pkg::CFG_EVAP_CHECK_TIME:   cfg_next.evap_check_time   = cfg_wdata;
                dhs_pkg::CFG_PLUGIN_CHECK_TIME: cfg_next.plugin_check_time = cfg_wdata;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warm_threshold    <= dhs_pkg::RstWarmThreshold;
            cfg_reg.heater_timeout    <= dhs_pkg::RstHeaterTimeout;
            cfg_reg.dropper_time      <= dhs_pkg::RstDropperTime;
            cfg_reg.evap_check_time   <= dhs_pkg::RstEvapCheckTime;
            cfg_reg.plugin_check_time <= dhs_pkg::RstPluginCheckTime;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/dhs_step.sv @@
// ----------------------------------------------------------------------------
// dhs_step: one evaluation of the defrost controller
// Pure combinational next-state and result logic for a single request.
// ----------------------------------------------------------------------------
module dhs_step (
    input  dhs_pkg::cfg_t    cfg,
    input  dhs_pkg::state_t  cur,
    input  dhs_pkg::item_t   item,
    output dhs_pkg::state_t  nxt,
    output dhs_pkg::result_t res
);

    localparam int SumW = dhs_pkg::CntW + 1;

    logic [dhs_pkg::CntW-1:0] since_tick;
    logic [dhs_pkg::CntW-1:0] el;
    logic [SumW-1:0]          on_total;
    logic [SumW-1:0]          drip_total;
    logic [SumW-1:0]          drip_plus_el;
    logic                     warm;
    logic                     idle_in;
    logic                     d_flag;
    logic                     p_flag;
    logic                     beep;
    logic                     comp_reset;
    dhs_pkg::state_t          s;

    assign warm = item.evap_reading >= cfg.warm_threshold;

    always_comb begin
        since_tick = cur.since_mark;
        if (item.tick && cur.mark_running && (cur.since_mark != dhs_pkg::CntSat)) begin
            since_tick = cur.since_mark + 1'b1;
        end

        // requests only count when no cycle is running; plug-in wins
        idle_in = !cur.defrost_flag && !cur.plugin_flag;
        d_flag  = cur.defrost_flag;
        p_flag  = cur.plugin_flag;
        if (idle_in) begin
            p_flag = item.plugin_request;
            d_flag = !item.plugin_request && item.defrost_request;
        end

        el           = cur.mark_running ? since_tick : '0;
        on_total     = {1'b0, cur.on_seconds} + {1'b0, el};
        drip_total   = {1'b0, cur.drip_seconds} + {1'b0, el};
        drip_plus_el = drip_total;

        s              = cur;
        s.since_mark   = since_tick;
        s.defrost_flag = d_flag;
        s.plugin_flag  = p_flag;
        beep           = 1'b0;
        comp_reset     = 1'b0;

        if (d_flag || p_flag) begin
            if (item.evap_error) begin
                // sensor fault aborts the running cycle; the heat error flag is kept
                s.heater_on    = 1'b0;
                s.defrost_flag = 1'b0;
                s.plugin_flag  = 1'b0;
                s.on_seconds   = '0;
                s.drip_seconds = '0;
                s.mark_running = 1'b0;
                s.since_mark   = '0;
                comp_reset     = 1'b1;
            end else if (cur.heater_on) begin
                if (p_flag) begin
                    if (on_total > {1'b0, cfg.plugin_check_time}) begin
                        s.plugin_flag = 1'b0;
                        if (!warm) begin
                            s.defrost_flag = 1'b1;
                        end else begin
                            s.heater_on    = 1'b0;
                            s.on_seconds   = '0;
                            s.drip_seconds = '0;
                            s.mark_running = 1'b0;
                            s.since_mark   = '0;
                            comp_reset     = 1'b1;
                        end
                    end
                end else if ((on_total > {1'b0, cfg.evap_check_time} && warm) ||
                             (on_total > {1'b0, cfg.heater_timeout})) begin
                    if (warm) begin
                        s.heat_error_flag = 1'b0;
                    end else if (!cur.heat_error_flag) begin
                        s.heat_error_flag = 1'b1;
                        beep              = 1'b1;
                    end
                    // heater off: bank on-time, start the drip period
                    s.heater_on    = 1'b0;
                    s.on_seconds   = on_total[SumW-1] ? dhs_pkg::CntSat
                                                      : on_total[dhs_pkg::CntW-1:0];
                    if (cur.drip_seconds == '0) begin
                        s.drip_seconds = dhs_pkg::CntW'(1);
                    end
                    s.mark_running = 1'b1;
                    s.since_mark   = '0;
                end
            end else begin
                if (cur.on_seconds == '0) begin
                    if (warm) begin
                        if (p_flag) begin
                            s.plugin_flag = 1'b0;
                        end else begin
                            s.on_seconds   = dhs_pkg::CntW'(1);
                            s.mark_running = 1'b1;
                            s.since_mark   = '0;
                        end
                    end else begin
                        s.heater_on    = 1'b1;
                        s.drip_seconds = drip_plus_el[SumW-1] ? dhs_pkg::CntSat
                                                              : drip_plus_el[dhs_pkg::CntW-1:0];
                        s.on_seconds   = dhs_pkg::CntW'(1);
                        s.mark_running = 1'b1;
                        s.since_mark   = '0;
                    end
                end else if (drip_total > {1'b0, cfg.dropper_time}) begin
                    s.defrost_flag = 1'b0;
                    s.on_seconds   = '0;
                    s.drip_seconds = '0;
                    s.mark_running = 1'b0;
                    s.since_mark   = '0;
                    comp_reset     = 1'b1;
                end
            end
        end

        nxt                        = s;
        res.heater_drive           = s.heater_on;
        res.defrost_active         = s.defrost_flag;
        res.plugin_active          = s.plugin_flag;
        res.heat_error             = s.heat_error_flag;
        res.beep                   = beep;
        res.compressor_timer_reset = comp_reset;
    end

endmodule

@@ rtl/defrost_heater_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// defrost_heater_sequencer_core: defrost heater sequencer top level
// Input register, controller state, one-pass evaluation and result register.
// ----------------------------------------------------------------------------
//  channel   | ports              | payload
//  ----------+--------------------+------------------------------------------
//  input     | s_tvalid/s_tready  | s_tdata: evaluation request (24 bits)
//  result    | m_tvalid/m_tready  | m_tdata: controller outputs (8 bits)
//  config    | cfg_wr_en          | cfg_index, cfg_wdata (16 bits)
//
//  One request per cycle sustained while m_tready is high; m_tvalid follows
//  an s_ accept through the input register, then the result register.
//  Reset (aresetn low, synchronous) clears state and config to defaults.
//  A stalled result holds the result register; the input register still
//  takes one more request, after which s_tready drops until m_tready returns.
module defrost_heater_sequencer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] tick, [1] defrost_request, [2] plugin_request, [3] evap_error,
    // [19:4] evap_reading (signed), [23:20] zero
    input  logic [dhs_pkg::InTdataW-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] heater_drive, [1] defrost_active, [2] plugin_active, [3] heat_error,
    // [4] beep, [5] compressor_timer_reset, [7:6] zero
    output logic [dhs_pkg::OutTdataW-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [dhs_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [dhs_pkg::CfgDataW-1:0]    cfg_wdata
);

    localparam int ItemW = $bits(dhs_pkg::item_t);
    localparam int ResW  = $bits(dhs_pkg::result_t);

    dhs_pkg::cfg_t    cfg;
    dhs_pkg::state_t  state_reg;
    dhs_pkg::state_t  state_next;
    dhs_pkg::item_t   item_reg;
    dhs_pkg::result_t res_reg;
    dhs_pkg::result_t res_next;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             s_take;

    dhs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dhs_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // evaluate when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= dhs_pkg::StateRst;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg <= dhs_pkg::item_t'(s_tdata[ItemW-1:0]);
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dhs_pkg::OutTdataW-ResW){1'b0}}, res_reg};

endmodule

@@ rtl/dhs_checker.sv @@
// ----------------------------------------------------------------------------
// dhs_checker: port-level checks for the defrost heater sequencer
// Watches the result stream for handshake and controller consistency.
// ----------------------------------------------------------------------------
module dhs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dhs_pkg::OutTdataW-1:0]  m_tdata
);

    // stalled result must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // both run flags never set together
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("defrost and plug-in flags both set");

    // a beep only comes with a freshly raised heat error
    a_beep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3])
        else $error("beep without heat error");

    // cycle end leaves heater off and the controller idle
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> !m_tdata[0] && !m_tdata[1] && !m_tdata[2])
        else $error("compressor reset while cycle still running");

    // nothing pending right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind defrost_heater_sequencer_core dhs_checker u_dhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/tb_defrost_heater_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// tb_defrost_heater_sequencer_core: self-checking bench for the defrost core
// Drives evaluation requests over the input stream and checks every result
// against its pinned table value or a cycle-free predictor of the controller.
// A short table covers start, abort, plug-in precedence and handover, then
// random phases under varied settings, sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_defrost_heater_sequencer_core;
    import dhs_pkg::*;

    localparam int QuietLimit = 4000;

    localparam result_t ResIdle        = '0;
    localparam result_t ResAbort       = '{compressor_timer_reset: 1'b1, default: 1'b0};
    localparam result_t ResDefrostHold = '{defrost_active: 1'b1, default: 1'b0};
    localparam result_t ResPluginHeat  = '{heater_drive: 1'b1, plugin_active: 1'b1,
                                           default: 1'b0};
    localparam result_t ResDefrostHeat = '{heater_drive: 1'b1, defrost_active: 1'b1,
                                           default: 1'b0};

    typedef struct {
        item_t   stim;
        bit      pinned;
        result_t res;
    } directed_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // [0] tick, [1] defrost_request, [2] plugin_request, [3] evap_error,
    // [19:4] evap_reading, [23:20] zero
    logic [InTdataW-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [0] heater_drive, [1] defrost_active, [2] plugin_active, [3] heat_error,
    // [4] beep, [5] compressor_timer_reset, [7:6] zero
    logic [OutTdataW-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    cfg_index_t           cfg_index = CFG_WARM_THRESHOLD;
    logic [CfgDataW-1:0]  cfg_wdata = '0;

    // expectation typed into the table travels alongside the request
    bit      pinned_flag = 1'b0;
    result_t pinned_res  = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned warm_pct       = 50;
    int unsigned mismatch_count = 0;
    int unsigned result_index   = 0;
    int unsigned quiet_cycles   = 0;

    result_t expected_results [$];

    string result_field_names [6] = '{"heater_drive", "defrost_active", "plugin_active",
                                      "heat_error", "beep", "compressor_timer_reset"};

    // predictor copy of controller state and settings
    logic            ctl_heater    = 1'b0;
    logic            ctl_defrost   = 1'b0;
    logic            ctl_plugin    = 1'b0;
    logic            ctl_heat_err  = 1'b0;
    logic [CntW-1:0] ctl_on_secs   = '0;
    logic [CntW-1:0] ctl_drip_secs = '0;
    logic            ctl_timing    = 1'b0;
    logic [CntW-1:0] ctl_since     = '0;
    cfg_t shadow_cfg = '{warm_threshold: RstWarmThreshold, heater_timeout: RstHeaterTimeout,
                         dropper_time: RstDropperTime, evap_check_time: RstEvapCheckTime,
                         plugin_check_time: RstPluginCheckTime};

    // columns: {evap_reading, evap_error, plugin_request, defrost_request, tick}
    directed_row_t directed_rows [20] = '{
        '{'{16'sd0,     1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, ResIdle},
        '{'{16'sh8000,  1'b1, 1'b0, 1'b0, 1'b1}, 1'b1, ResIdle},        // error while idle
        '{'{16'sh7FFF,  1'b1, 1'b0, 1'b1, 1'b0}, 1'b1, ResAbort},
        '{'{16'sh7FFF,  1'b0, 1'b1, 1'b1, 1'b0}, 1'b1, ResIdle},        // plug-in wins, warm
        '{'{16'sh7FFF,  1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, ResDefrostHold}, // warm start, no heat
        '{'{16'sd100,   1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, ResIdle},
        '{'{16'shFFFF,  1'b1, 1'b1, 1'b0, 1'b0}, 1'b1, ResAbort},
        '{'{16'sd99,    1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, ResPluginHeat},
        '{'{16'shFFFF,  1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, ResIdle},
        '{'{16'shFFFF,  1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, ResIdle},
        '{'{16'shFFFF,  1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, ResIdle},
        '{'{16'shFFFF,  1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, ResIdle},
        '{'{16'shFFFF,  1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, ResIdle},        // cold handover
        '{'{16'sh8000,  1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, ResIdle},
        '{'{16'sd0,     1'b1, 1'b0, 1'b0, 1'b1}, 1'b1, ResAbort},
        '{'{16'shFF9C,  1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, ResDefrostHeat},
        '{'{16'sd500,   1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, ResIdle},        // warm before check
        '{'{16'sh5555,  1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, ResIdle},
        '{'{16'shAAAA,  1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, ResIdle},
        '{'{16'sd0,     1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, ResAbort}
    };

    defrost_heater_sequencer_core uut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] error: %s", $time, msg);
    endtask

    function automatic logic [CntW-1:0] sat_add16(logic [CntW-1:0] a, logic [CntW-1:0] b);
        logic [CntW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CntW] ? CntSat : sum[CntW-1:0];
    endfunction

    function automatic logic [CntW-1:0] mark_elapsed();
        return ctl_timing ? ctl_since : '0;
    endfunction

    function automatic void restart_mark();
        ctl_timing = 1'b1;
        ctl_since  = '0;
    endfunction

    function automatic void clear_timers();
        ctl_on_secs   = '0;
        ctl_drip_secs = '0;
        ctl_timing    = 1'b0;
        ctl_since     = '0;
    endfunction

    // callers only ever flip the heater, so no same-state check here
    function automatic void switch_heater(logic want);
        ctl_heater = want;
        if (want) begin
            ctl_drip_secs = sat_add16(ctl_drip_secs, mark_elapsed());
            if (ctl_on_secs == '0) ctl_on_secs = 16'd1;
        end else begin
            ctl_on_secs = sat_add16(ctl_on_secs, mark_elapsed());
            if (ctl_drip_secs == '0) ctl_drip_secs = 16'd1;
        end
        restart_mark();
    endfunction

    function automatic result_t evaluate_step(item_t stim);
        result_t       r;
        logic          warm;
        logic [CntW:0] heat_total;
        logic [CntW:0] drip_total;
        r = '0;
        warm = $signed(stim.evap_reading) >= $signed(shadow_cfg.warm_threshold);
        if (stim.tick && ctl_timing && ctl_since != CntSat) ctl_since = ctl_since + 16'd1;
        if (!ctl_defrost && !ctl_plugin) begin
            if (stim.plugin_request) ctl_plugin = 1'b1;
            else if (stim.defrost_request) ctl_defrost = 1'b1;
        end
        // unsaturated sums for the threshold compares
        heat_total = {1'b0, ctl_on_secs} + {1'b0, mark_elapsed()};
        drip_total = {1'b0, ctl_drip_secs} + {1'b0, mark_elapsed()};
        if (ctl_defrost || ctl_plugin) begin
            if (stim.evap_error) begin
                ctl_heater  = 1'b0;
                ctl_defrost = 1'b0;
                ctl_plugin  = 1'b0;
                clear_timers();
                r.compressor_timer_reset = 1'b1;
            end else if (ctl_heater) begin
                if (ctl_plugin) begin
                    if (heat_total > {1'b0, shadow_cfg.plugin_check_time}) begin
                        ctl_plugin = 1'b0;
                        if (!warm) begin
                            ctl_defrost = 1'b1;
                        end else begin
                            ctl_heater = 1'b0;
                            clear_timers();
                            r.compressor_timer_reset = 1'b1;
                        end
                    end
                end else if ((heat_total > {1'b0, shadow_cfg.evap_check_time} && warm)
                             || heat_total > {1'b0, shadow_cfg.heater_timeout}) begin
                    if (warm) begin
                        ctl_heat_err = 1'b0;
                    end else if (!ctl_heat_err) begin
                        ctl_heat_err = 1'b1;
                        r.beep = 1'b1;
                    end
                    switch_heater(1'b0);
                end
            end else if (ctl_on_secs == '0) begin
                if (warm) begin
                    if (ctl_plugin) begin
                        ctl_plugin = 1'b0;
                    end else begin
                        ctl_on_secs = 16'd1;
                        restart_mark();
                    end
                end else begin
                    switch_heater(1'b1);
                end
            end else if (drip_total > {1'b0, shadow_cfg.dropper_time}) begin
                ctl_defrost = 1'b0;
                clear_timers();
                r.compressor_timer_reset = 1'b1;
            end
        end
        r.heater_drive   = ctl_heater;
        r.defrost_active = ctl_defrost;
        r.plugin_active  = ctl_plugin;
        r.heat_error     = ctl_heat_err;
        return r;
    endfunction

    // readings cluster around the warm threshold, with a drifting warm bias
    function automatic item_t random_item();
        item_t stim;
        int    thr;
        int    lo;
        int    hi;
        int    v;
        bit    want_warm;
        if ($urandom_range(15) == 0) warm_pct = $urandom_range(100);
        thr = $signed(shadow_cfg.warm_threshold);
        want_warm = ($urandom_range(99) < warm_pct) || (thr == -32768);
        if (want_warm) begin
            lo = thr;
            hi = 32767;
        end else begin
            lo = -32768;
            hi = thr - 1;
        end
        if ($urandom_range(1)) v = want_warm ? lo + int'($urandom_range(2))
                                             : hi - int'($urandom_range(2));
        else v = lo + int'($urandom_range(hi - lo));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        stim.evap_reading    = v[15:0];
        stim.tick            = $urandom_range(99) < 75;
        stim.defrost_request = $urandom_range(99) < 15;
        stim.plugin_request  = $urandom_range(99) < 8;
        stim.evap_error      = $urandom_range(99) < 2;
        return stim;
    endfunction

    always @(posedge aclk) begin : scoreboard
        result_t seen;
        result_t want;
        item_t   arrived;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen = m_tdata[$bits(result_t)-1:0];
                if (m_tdata[OutTdataW-1:$bits(result_t)] != '0)
                    flag_mismatch($sformatf("result %0d padding bits set", result_index));
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("result %0d with nothing pending", result_index));
                end else begin
                    want = expected_results.pop_front();
                    for (int b = 0; b < $bits(result_t); b++)
                        if (seen[b] !== want[b])
                            flag_mismatch($sformatf("result %0d %s got %b want %b",
                                result_index, result_field_names[b], seen[b], want[b]));
                end
                result_index++;
            end
            if (s_tvalid && s_tready) begin
                arrived = s_tdata[$bits(item_t)-1:0];
                want = evaluate_step(arrived);
                expected_results.push_back(pinned_flag ? pinned_res : want);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QuietLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(item_t stim, bit pinned, result_t res);
        s_tvalid    <= 1'b1;
        s_tdata     <= {{(InTdataW-$bits(item_t)){1'b0}}, stim};
        pinned_flag <= pinned;
        pinned_res  <= res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_setting(cfg_index_t idx, logic [CfgDataW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_WARM_THRESHOLD:    shadow_cfg.warm_threshold    = val;
            CFG_HEATER_TIMEOUT:    shadow_cfg.heater_timeout    = val;
            CFG_DROPPER_TIME:      shadow_cfg.dropper_time      = val;
            CFG_EVAP_CHECK_TIME:   shadow_cfg.evap_check_time   = val;
            CFG_PLUGIN_CHECK_TIME: shadow_cfg.plugin_check_time = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [15:0] warm, logic [15:0] timeout,
                                  logic [15:0] drip, logic [15:0] evap_chk,
                                  logic [15:0] plug_chk);
        write_setting(CFG_WARM_THRESHOLD, warm);
        write_setting(CFG_HEATER_TIMEOUT, timeout);
        write_setting(CFG_DROPPER_TIME, drip);
        write_setting(CFG_EVAP_CHECK_TIME, evap_chk);
        write_setting(CFG_PLUGIN_CHECK_TIME, plug_chk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // table runs at reset settings
        foreach (directed_rows[i])
            send_request(directed_rows[i].stim, directed_rows[i].pinned, directed_rows[i].res);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            if (p == 2)
                apply_settings(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0);
            else if (p == 6)
                apply_settings(16'h7FFF, 16'($urandom_range(24)), 16'($urandom_range(12)),
                               16'($urandom_range(10)), 16'($urandom_range(8)));
            else
                apply_settings(16'($urandom_range(65535)), 16'($urandom_range(24)),
                               16'($urandom_range(12)), 16'($urandom_range(10)),
                               16'($urandom_range(8)));
            repeat (235) send_request(random_item(), 1'b0, ResIdle);
            wait_drained();
        end

        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
